// File: design/acalu_pkg.sv
// Shared types, codes and helpers for the conditional ALU execute block.
package acalu_pkg;

   // Register file geometry
   localparam int REG_COUNT_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int IDX_W         = 4;

   // Program counter register and its read offset
   localparam logic [IDX_W-1:0] PC_INDEX  = 4'd15;
   localparam logic [3:0]       PC_OFFSET = 4'd8;

   // Operation codes
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_ADC  = 3'd1,
      OP_AND  = 3'd2,
      OP_MOVR = 3'd3,
      OP_MOVI = 3'd4
   } op_type;

   // Condition codes
   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;

   // Condition flags
   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

   // Input word
   typedef struct packed {
      op_type            req_type;
      logic              set_flags;
      logic [3:0]        cond_code;
      logic [IDX_W-1:0]  dest_index;
      logic [IDX_W-1:0]  first_index;
      logic [IDX_W-1:0]  second_index;
      logic [DATA_W-1:0] imm_value;
   } req_word_type;

   // Result word
   typedef struct packed {
      logic              executed;
      logic [IDX_W-1:0]  written_index;
      logic [DATA_W-1:0] written_value;
      logic              flag_neg;
      logic              flag_zero;
      logic              flag_carry;
      logic              flag_ovf;
   } rsp_word_type;

   // Condition test against the stored flags
   function automatic logic cond_pass(input logic [3:0] code, input flags_type f);
      logic pass;
      unique case (code)
         COND_EQ: pass = f.z;
         COND_NE: pass = !f.z;
         COND_CS: pass = f.c;
         COND_CC: pass = !f.c;
         COND_MI: pass = f.n;
         COND_PL: pass = !f.n;
         COND_VS: pass = f.v;
         COND_VC: pass = !f.v;
         COND_HI: pass = f.c && !f.z;
         COND_LS: pass = !f.c || f.z;
         COND_GE: pass = (f.n == f.v);
         COND_LT: pass = (f.n != f.v);
         COND_GT: pass = (f.n == f.v) && !f.z;
         COND_LE: pass = (f.n != f.v) || f.z;
         COND_AL: pass = 1'b1;
         default: pass = 1'b0;
      endcase
      return pass;
   endfunction

endpackage

// File: design/acalu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module acalu_ram
   import acalu_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = REG_COUNT_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/arm_conditional_alu_execute.sv
// Top level of the conditional ALU execute block: register file, flags, pipeline.
//
// Usage: one decoded operation per input word on req_valid/req_ready/req_data;
// one result word per input on rsp_valid/rsp_ready/rsp_data, in order.
// Each word is tested against the stored N, Z, C, V flags; a passing word writes
// its destination and may update the flags, save ADC naming PC and unused opcodes.
// The result word is registered: the register file read is launched at the accept
// edge together with the execute stage register, and the ALU result lands in the
// output register when that stage advances. Throughput: one word per cycle
// while rsp_ready holds, also for back-to-back dependent words; the single
// write port of the register file and the previous-result bypass set that rate.
// The register file sits in two 16x32 RAMs (one per source operand) with a
// registered read; a per-entry valid bit makes unwritten registers read as zero.
// Reset clears the flags, the valid bits and the pipeline; no clearing pass.
// When the receiver holds rsp_ready low, the result stays in the output
// register, one more word waits in the execute stage, and req_ready drops.
module arm_conditional_alu_execute
   import acalu_pkg::*;
#(
   parameter int REG_COUNT = REG_COUNT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int AW = $clog2(REG_COUNT);

   // Pipeline registers
   logic              s1_vld_ff, s1_vld_in;
   req_word_type      s1_ff;
   logic              rsp_vld_ff, rsp_vld_in;
   rsp_word_type      rsp_ff;
   flags_type         flags_ff, flags_in;
   logic [REG_COUNT-1:0] vld_ff, vld_in;
   logic              fwd_vld_ff;
   logic [AW-1:0]     fwd_idx_ff;
   logic [DATA_W-1:0] fwd_data_ff;

   logic              req_acc;
   logic              s1_adv;
   logic [AW-1:0]     rd_a_addr, rd_b_addr;
   logic [DATA_W-1:0] ram_a, ram_b;
   logic [DATA_W-1:0] opa, opb;
   logic [AW-1:0]     rn, rm, rd;

   // ALU results
   logic              pass, exec, pc_ref;
   logic [3:0]        addk;
   logic [33:0]       usum, ssum;
   logic [DATA_W-1:0] res;
   flags_type         flags_nx;
   rsp_word_type      rsp_nx;

   // Handshake
   assign s1_adv    = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign rn = s1_ff.first_index[AW-1:0];
   assign rm = s1_ff.second_index[AW-1:0];
   assign rd = s1_ff.dest_index[AW-1:0];

   // Read addresses: new word on accept, else re-read the held word
   assign rd_a_addr = req_acc ? req_data.first_index[AW-1:0]  : rn;
   assign rd_b_addr = req_acc ? req_data.second_index[AW-1:0] : rm;

   acalu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_a (
      .clock   (clock),
      .wr_en   (s1_adv && exec),
      .wr_addr (rd),
      .wr_data (res),
      .rd_addr (rd_a_addr),
      .rd_data (ram_a)
   );

   acalu_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_b (
      .clock   (clock),
      .wr_en   (s1_adv && exec),
      .wr_addr (rd),
      .wr_data (res),
      .rd_addr (rd_b_addr),
      .rd_data (ram_b)
   );

   // Operand select: bypass of last write, then RAM, unwritten reads zero
   always_comb begin
      if (fwd_vld_ff && fwd_idx_ff == rn) begin
         opa = fwd_data_ff;
      end else if (vld_ff[rn]) begin
         opa = ram_a;
      end else begin
         opa = '0;
      end
      if (fwd_vld_ff && fwd_idx_ff == rm) begin
         opb = fwd_data_ff;
      end else if (vld_ff[rm]) begin
         opb = ram_b;
      end else begin
         opb = '0;
      end
   end

   // Shared adder for ADD and ADC
   always_comb begin
      pc_ref = (s1_ff.first_index == PC_INDEX) || (s1_ff.second_index == PC_INDEX);
      if (s1_ff.req_type == OP_ADD) begin
         addk = pc_ref ? PC_OFFSET : 4'd0;
      end else begin
         addk = {3'd0, flags_ff.c};
      end
      usum = {2'b00, opa} + {2'b00, opb} + {30'd0, addk};
      ssum = {{2{opa[31]}}, opa} + {{2{opb[31]}}, opb} + {30'd0, addk};
   end

   // Execute: condition test, result and flag update
   always_comb begin
      pass     = cond_pass(s1_ff.cond_code, flags_ff);
      exec     = 1'b0;
      res      = '0;
      flags_nx = flags_ff;
      unique case (s1_ff.req_type)
         OP_ADD: begin
            exec = pass;
            res  = usum[DATA_W-1:0];
            if (s1_ff.set_flags) begin
               flags_nx.n = usum[31];
               flags_nx.z = (usum[DATA_W-1:0] == '0);
               flags_nx.c = (usum[33:32] != 2'b00);
               flags_nx.v = !((ssum[33:31] == 3'b000) || (ssum[33:31] == 3'b111));
            end
         end
         OP_ADC: begin
            exec = pass && !pc_ref && (s1_ff.dest_index != PC_INDEX);
            res  = usum[DATA_W-1:0];
            if (s1_ff.set_flags) begin
               flags_nx.n = usum[31];
               flags_nx.z = (usum[DATA_W-1:0] == '0);
               flags_nx.c = (usum[33:32] != 2'b00);
               flags_nx.v = !((ssum[33:31] == 3'b000) || (ssum[33:31] == 3'b111));
            end
         end
         OP_AND: begin
            exec = pass;
            res  = opa & opb;
            if (s1_ff.set_flags) begin
               flags_nx.n = res[31];
               flags_nx.z = (res == '0);
               flags_nx.v = 1'b0;
            end
         end
         OP_MOVR: begin
            exec = pass;
            res  = opa;
            if (s1_ff.set_flags) begin
               flags_nx.n = res[31];
               flags_nx.z = (res == '0);
            end
         end
         OP_MOVI: begin
            exec = pass;
            res  = s1_ff.imm_value;
         end
         default: begin
            exec = 1'b0;
         end
      endcase
      if (!exec) begin
         flags_nx = flags_ff;
         res      = '0;
      end
      rsp_nx.executed      = exec;
      rsp_nx.written_index = s1_ff.dest_index;
      rsp_nx.written_value = res;
      rsp_nx.flag_neg      = flags_nx.n;
      rsp_nx.flag_zero     = flags_nx.z;
      rsp_nx.flag_carry    = flags_nx.c;
      rsp_nx.flag_ovf      = flags_nx.v;
   end

   // Next state for control registers
   always_comb begin
      s1_vld_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
      rsp_vld_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);
      flags_in   = s1_adv ? flags_nx : flags_ff;
      vld_in     = vld_ff;
      if (s1_adv && exec) begin
         vld_in[rd] = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         flags_ff   <= '0;
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         flags_ff   <= flags_in;
         vld_ff     <= vld_in;
         if (s1_adv && exec) begin
            fwd_vld_ff <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_nx;
      end
      if (s1_adv && exec) begin
         fwd_idx_ff  <= rd;
         fwd_data_ff <= res;
      end
   end

   // Checks
   a_no_exec_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.executed |-> rsp_data.written_value == '0)
      else $error("skipped word carries a nonzero value");

   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      s1_adv && !exec |=> flags_ff == $past(flags_ff))
      else $error("flags changed by a skipped word");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (!rsp_vld_ff || rsp_ready) |-> req_ready)
      else $error("input stalled while output can drain");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_data.flag_carry == flags_ff.c && rsp_data.flag_ovf == flags_ff.v)
      else $error("result flags differ from stored flags");

endmodule

// File: sim/alu_checker.sv
// Checker for the conditional ALU: predicts each result word and compares it in order.
module alu_checker
   import acalu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_data,
   output int           error_count,
   output int           results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the architectural state
   logic [DATA_W-1:0] reg_shadow [REG_COUNT_DEF];
   flags_type         flag_shadow;

   // Predicted result words, oldest first
   rsp_word_type      result_q [$];

   // Condition test against the shadow flags
   function automatic logic cond_met(input logic [3:0] code);
      logic hit;
      case (code)
         COND_EQ: hit = flag_shadow.z;
         COND_NE: hit = !flag_shadow.z;
         COND_CS: hit = flag_shadow.c;
         COND_CC: hit = !flag_shadow.c;
         COND_MI: hit = flag_shadow.n;
         COND_PL: hit = !flag_shadow.n;
         COND_VS: hit = flag_shadow.v;
         COND_VC: hit = !flag_shadow.v;
         COND_HI: hit = flag_shadow.c && !flag_shadow.z;
         COND_LS: hit = !flag_shadow.c || flag_shadow.z;
         COND_GE: hit = (flag_shadow.n == flag_shadow.v);
         COND_LT: hit = (flag_shadow.n != flag_shadow.v);
         COND_GT: hit = (flag_shadow.n == flag_shadow.v) && !flag_shadow.z;
         COND_LE: hit = (flag_shadow.n != flag_shadow.v) || flag_shadow.z;
         COND_AL: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   // Three-term add; carry and overflow come from the full sum
   function automatic logic [DATA_W-1:0] add_update(input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b,
                                                    input logic [3:0] k,
                                                    input logic sf);
      logic [DATA_W+1:0]  usum;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic signed [63:0] ssum;
      usum = {2'b00, a} + {2'b00, b} + {30'd0, k};
      sa   = $signed(a);
      sb   = $signed(b);
      ssum = sa + sb + $signed({60'd0, k});
      if (sf) begin
         flag_shadow.n = usum[DATA_W-1];
         flag_shadow.z = (usum[DATA_W-1:0] == '0);
         flag_shadow.c = (usum[DATA_W+1:DATA_W] != 2'b00);
         flag_shadow.v = (ssum[63:31] != {33{ssum[31]}});
      end
      return usum[DATA_W-1:0];
   endfunction

   // Run one input word against the shadow state and build its result word
   function automatic rsp_word_type execute_word(input req_word_type w);
      rsp_word_type      r;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] res;
      logic              ran;
      logic              pc_read;
      a       = reg_shadow[w.first_index];
      b       = reg_shadow[w.second_index];
      res     = '0;
      ran     = 1'b0;
      pc_read = (w.first_index == PC_INDEX) || (w.second_index == PC_INDEX);
      if (cond_met(w.cond_code)) begin
         case (w.req_type)
            OP_ADD: begin
               res = add_update(a, b, pc_read ? PC_OFFSET : 4'd0, w.set_flags);
               ran = 1'b1;
            end
            OP_ADC: begin
               // naming the PC as a source or as the destination turns ADC into a no-op
               if (!pc_read && w.dest_index != PC_INDEX) begin
                  res = add_update(a, b, {3'b000, flag_shadow.c}, w.set_flags);
                  ran = 1'b1;
               end
            end
            OP_AND: begin
               res = a & b;
               if (w.set_flags) begin
                  flag_shadow.n = res[DATA_W-1];
                  flag_shadow.z = (res == '0);
                  flag_shadow.v = 1'b0;
               end
               ran = 1'b1;
            end
            OP_MOVR: begin
               res = a;
               if (w.set_flags) begin
                  flag_shadow.n = res[DATA_W-1];
                  flag_shadow.z = (res == '0);
               end
               ran = 1'b1;
            end
            OP_MOVI: begin
               res = w.imm_value;
               ran = 1'b1;
            end
            default: ;
         endcase
      end
      if (ran)
         reg_shadow[w.dest_index] = res;
      r.executed      = ran;
      r.written_index = w.dest_index;
      r.written_value = ran ? res : '0;
      r.flag_neg      = flag_shadow.n;
      r.flag_zero     = flag_shadow.z;
      r.flag_carry    = flag_shadow.c;
      r.flag_ovf      = flag_shadow.v;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Sample both channels at the rising edge
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         for (int i = 0; i < REG_COUNT_DEF; i++)
            reg_shadow[i] = '0;
         flag_shadow = '0;
         result_q.delete();
         results_due = 0;
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               $error("result word with nothing expected: %p", rsp_data);
               error_count++;
            end else begin
               want = result_q.pop_front();
               check_field("executed", DATA_W'(want.executed),
                           DATA_W'(rsp_data.executed));
               check_field("written_index", DATA_W'(want.written_index),
                           DATA_W'(rsp_data.written_index));
               check_field("written_value", want.written_value, rsp_data.written_value);
               check_field("flag_neg", DATA_W'(want.flag_neg),
                           DATA_W'(rsp_data.flag_neg));
               check_field("flag_zero", DATA_W'(want.flag_zero),
                           DATA_W'(rsp_data.flag_zero));
               check_field("flag_carry", DATA_W'(want.flag_carry),
                           DATA_W'(rsp_data.flag_carry));
               check_field("flag_ovf", DATA_W'(want.flag_ovf),
                           DATA_W'(rsp_data.flag_ovf));
            end
         end
         if (req_valid && req_ready)
            result_q.push_back(execute_word(req_data));
         results_due = result_q.size();
      end
   end

endmodule

// File: sim/tb_top.sv
// Testbench top for the conditional ALU: clock, reset, stimulus, watchdog and verdict.
module tb_top;
   import acalu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         STALL_LIMIT     = 1000;
   localparam int         LONG_HOLD       = 150;
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam logic [3:0] COND_NEVER      = 4'd15;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   int           error_count;
   int           results_due;

   // Flags shared between the sender and the receiver; idle count of the watchdog
   logic         quiet;
   logic         long_hold_req;
   int           idle_cycles;

   arm_conditional_alu_execute u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   alu_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .error_count (error_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
   end

   function automatic req_word_type make_word(input op_type op, input logic sf,
                                              input logic [3:0] cond,
                                              input logic [3:0] rd, input logic [3:0] rn,
                                              input logic [3:0] rm,
                                              input logic [DATA_W-1:0] imm);
      req_word_type w;
      w.req_type     = op;
      w.set_flags    = sf;
      w.cond_code    = cond;
      w.dest_index   = rd;
      w.first_index  = rn;
      w.second_index = rm;
      w.imm_value    = imm;
      return w;
   endfunction

   // Random word: mostly executing operations, extreme immediates, a few unused opcodes
   function automatic req_word_type random_word();
      req_word_type      w;
      logic [2:0]        op_bits;
      logic [DATA_W-1:0] imm;
      if ($urandom_range(0, 99) < 3)
         op_bits = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      else
         op_bits = 3'($urandom_range(OP_ADD, OP_MOVI));
      case ($urandom_range(0, 5))
         0:       imm = '0;
         1:       imm = '1;
         2:       imm = 32'h8000_0000;
         3:       imm = 32'h7FFF_FFFF;
         4:       imm = 32'd1;
         default: imm = $urandom;
      endcase
      w = make_word(op_type'(op_bits), 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : COND_AL,
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), imm);
      return w;
   endfunction

   // Offer one word, with an occasional gap ahead of it, and wait for acceptance
   task automatic send_word(input req_word_type w);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // Receiver: short random stalls, one long hold on request
   initial begin
      int hold_left;
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any handshake
   initial begin
      idle_cycles = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      req_valid     = 1'b0;
      req_data      = '0;
      quiet         = 1'b0;
      long_hold_req = 1'b0;
      wait (!reset);

      // Seed registers with extreme values
      send_word(make_word(OP_MOVI, 1'b1, COND_AL, 4'd1, 4'd0, 4'd0, 32'hFFFF_FFFF));
      send_word(make_word(OP_MOVI, 1'b0, COND_AL, 4'd2, 4'd0, 4'd0, 32'd1));
      send_word(make_word(OP_MOVI, 1'b0, COND_AL, 4'd3, 4'd0, 4'd0, 32'h8000_0000));
      send_word(make_word(OP_MOVI, 1'b0, COND_AL, 4'd4, 4'd0, 4'd0, 32'h7FFF_FFFF));
      // Carry out to zero, signed overflow, both at once, PC operand offset
      send_word(make_word(OP_ADD, 1'b1, COND_AL, 4'd5, 4'd1, 4'd2, '0));
      send_word(make_word(OP_ADD, 1'b1, COND_AL, 4'd6, 4'd4, 4'd2, '0));
      send_word(make_word(OP_ADD, 1'b1, COND_AL, 4'd7, 4'd3, 4'd3, '0));
      send_word(make_word(OP_ADD, 1'b1, COND_AL, 4'd8, PC_INDEX, 4'd1, '0));
      // ADC naming the PC does nothing
      send_word(make_word(OP_ADC, 1'b1, COND_AL, PC_INDEX, 4'd2, 4'd2, '0));
      send_word(make_word(OP_AND, 1'b1, COND_AL, 4'd9, 4'd1, 4'd3, '0));
      send_word(make_word(OP_MOVR, 1'b1, COND_AL, 4'd10, 4'd0, 4'd0, '0));
      send_word(make_word(op_type'(OP_UNUSED_FIRST), 1'b1, COND_AL, 4'd11, 4'd1, 4'd1,
                          32'h1234_5678));
      // Every condition code, flags churning as it goes
      for (int c = 0; c <= COND_NEVER; c++)
         send_word(make_word(($urandom_range(0, 1) == 0) ? OP_ADD : OP_ADC, 1'b1, 4'(c),
                             4'($urandom_range(1, 14)), 4'($urandom_range(1, 4)),
                             4'($urandom_range(1, 4)), '0));

      for (int i = 0; i < 700; i++)
         send_word(random_word());

      // Receiver holds off while the sender keeps offering
      long_hold_req = 1'b1;
      for (int i = 0; i < 300; i++)
         send_word(random_word());

      // Sender pauses until every result is back
      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_due == 0);

      for (int i = 0; i < 300; i++)
         send_word(random_word());

      quiet = 1'b1;
      for (int i = 0; i < 400; i++)
         send_word(random_word());

      @(negedge clock);
      req_valid <= 1'b0;
      wait (results_due == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0 && results_due == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
